>>> hw/rtl/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types, constants and the checksum step of the serial frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package sfr_pkg;

	localparam logic [7:0]  START_BYTE   = 8'h02;
	localparam logic [7:0]  ADDRESS_BYTE = 8'h80;
	localparam logic [15:0] CHECK_TOP    = 16'h8000;
	localparam logic [15:0] CHECK_POLY   = 16'h8005;

	localparam logic [7:0]  CMD_RESET = 8'd176;
	localparam logic [15:0] LEN_RESET = 16'd1007;

	localparam int unsigned PADDR_W = 3;
	localparam int unsigned PDATA_W = 32;

	// register index, taken from the word address bit
	localparam logic REG_EXP_CMD = 1'b0;
	localparam logic REG_EXP_LEN = 1'b1;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_LEN_MISMATCH = 2'd1,
		ST_CHECK_ERROR = 2'd2
	} status_t;

	typedef struct packed {
		logic [7:0]  expected_command;
		logic [15:0] expected_length_word;
	} cfg_t;

	function automatic logic [15:0] check_next(
		input logic [15:0] check,
		input logic [7:0]  prev,
		input logic [7:0]  b
	);
		logic [15:0] shifted;
		shifted = {check[14:0], 1'b0};
		if ((check & CHECK_TOP) != 16'h0000)
			shifted = shifted ^ CHECK_POLY;
		return shifted ^ {prev, b};
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/sfr_byte_if.sv
// ----------------------------------------------------------------------------
// sfr_byte_if
// Valid/ready channel carrying one received serial byte per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfr_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/sfr_result_if.sv
// ----------------------------------------------------------------------------
// sfr_result_if
// Valid/ready channel carrying one data byte or one end-of-frame status.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfr_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] payload_byte;
	logic       payload_valid;
	logic       frame_done;
	logic [1:0] status;

	modport source (
		output valid, output payload_byte, output payload_valid,
		output frame_done, output status, input ready
	);
	modport sink (
		input valid, input payload_byte, input payload_valid,
		input frame_done, input status, output ready
	);
endinterface

`default_nettype wire

>>> hw/rtl/sfr_cfg_regs.sv
// ----------------------------------------------------------------------------
// sfr_cfg_regs
// APB register file: expected command byte and expected length word.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_cfg_regs
	import sfr_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready,
	output cfg_t                    cfg
);

	cfg_t cfg_q;
	logic wr_en;
	logic reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = paddr[2];
	assign wr_en   = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.expected_command     <= CMD_RESET;
			cfg_q.expected_length_word <= LEN_RESET;
		end else if (wr_en) begin
			case (reg_sel)
				REG_EXP_CMD: cfg_q.expected_command <= pwdata[7:0];
				REG_EXP_LEN: cfg_q.expected_length_word <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (reg_sel)
			REG_EXP_CMD: prdata = {{(PDATA_W-8){1'b0}}, cfg_q.expected_command};
			REG_EXP_LEN: prdata = {{(PDATA_W-16){1'b0}}, cfg_q.expected_length_word};
			default: prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

>>> hw/rtl/sfr_in_stage.sv
// ----------------------------------------------------------------------------
// sfr_in_stage
// Input register: holds one byte until the frame parser takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_in_stage (
	input  wire logic  clk,
	input  wire logic  arst_n,
	sfr_byte_if.sink   rx,
	input  wire logic  take,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);

	logic load;

	assign rx.ready = !valid_s1 || take;
	assign load     = rx.valid && rx.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_s1 <= rx.rx_byte;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/sfr_parser.sv
// ----------------------------------------------------------------------------
// sfr_parser
// Frame state machine, checksum update and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_parser
	import sfr_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cfg_t       cfg,
	input  wire logic       valid_s1,
	input  wire logic [7:0] byte_s1,
	output logic            take,
	sfr_result_if.source    frame
);

	typedef enum logic [7:0] {
		PH_HUNT       = 8'b0000_0001,
		PH_ADDR       = 8'b0000_0010,
		PH_LEN_LO     = 8'b0000_0100,
		PH_LEN_HI     = 8'b0000_1000,
		PH_CMD        = 8'b0001_0000,
		PH_SIXTH_OK   = 8'b0010_0000,
		PH_SIXTH_DROP = 8'b0100_0000,
		PH_BODY       = 8'b1000_0000
	} phase_t;

	phase_t      phase_q, phase_n;
	logic [15:0] pos_q, pos_n;
	logic [15:0] check_q, check_n;
	logic [7:0]  prev_q, prev_n;
	logic [15:0] len_q, len_n;
	logic [7:0]  low_q, low_n;

	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        out_pv_q;
	logic        out_done_q;
	status_t     out_st_q;

	logic        emit;
	logic [7:0]  r_byte;
	logic        r_pv;
	logic        r_done;
	status_t     r_st;
	logic        body_en;
	logic [16:0] left;
	logic [16:0] left_m1;
	logic [15:0] check_upd;

	assign take      = valid_s1 && (!out_valid_q || frame.ready);
	assign check_upd = check_next(check_q, prev_q, byte_s1);
	assign left      = (phase_q == PH_BODY) ? {1'b0, pos_q} : ({1'b0, len_q} + 17'd1);
	assign left_m1   = left - 17'd1;

	always_comb begin
		phase_n = phase_q;
		pos_n   = pos_q;
		check_n = check_q;
		prev_n  = prev_q;
		len_n   = len_q;
		low_n   = low_q;
		emit    = 1'b0;
		r_byte  = 8'h00;
		r_pv    = 1'b0;
		r_done  = 1'b0;
		r_st    = ST_OK;
		body_en = 1'b0;

		case (phase_q)
			PH_HUNT: begin
				if (byte_s1 == START_BYTE) begin
					check_n = {8'h00, byte_s1};
					prev_n  = byte_s1;
					phase_n = PH_ADDR;
				end
			end
			PH_ADDR: begin
				if (byte_s1 == ADDRESS_BYTE) begin
					check_n = check_upd;
					prev_n  = byte_s1;
					phase_n = PH_LEN_LO;
				end else begin
					phase_n = PH_HUNT;
				end
			end
			PH_LEN_LO: begin
				check_n = check_upd;
				prev_n  = byte_s1;
				len_n   = {8'h00, byte_s1};
				phase_n = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				check_n = check_upd;
				prev_n  = byte_s1;
				len_n   = {byte_s1, len_q[7:0]};
				phase_n = PH_CMD;
			end
			PH_CMD: begin
				check_n = check_upd;
				prev_n  = byte_s1;
				phase_n = (byte_s1 == cfg.expected_command) ? PH_SIXTH_OK : PH_SIXTH_DROP;
			end
			PH_SIXTH_DROP: begin
				phase_n = PH_HUNT;
			end
			PH_SIXTH_OK: begin
				if (len_q != cfg.expected_length_word || len_q == 16'h0000) begin
					phase_n = PH_HUNT;
					emit    = 1'b1;
					r_done  = 1'b1;
					r_st    = ST_LEN_MISMATCH;
				end else begin
					body_en = 1'b1;
				end
			end
			PH_BODY: begin
				body_en = 1'b1;
			end
			default: begin
				phase_n = PH_HUNT;
			end
		endcase

		if (body_en) begin
			if (left == 17'd0) begin
				phase_n = PH_HUNT;
			end else begin
				pos_n   = left_m1[15:0];
				phase_n = PH_BODY;
				if (left > 17'd2) begin
					check_n = check_upd;
					prev_n  = byte_s1;
					emit    = 1'b1;
					r_byte  = byte_s1;
					r_pv    = 1'b1;
				end else if (left == 17'd2) begin
					low_n = byte_s1;
				end else begin
					// high checksum byte closes the frame
					phase_n = PH_HUNT;
					emit    = 1'b1;
					r_done  = 1'b1;
					r_st    = ({byte_s1, low_q} == check_q) ? ST_OK : ST_CHECK_ERROR;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			pos_q   <= '0;
			check_q <= '0;
			prev_q  <= '0;
			len_q   <= '0;
			low_q   <= '0;
		end else if (take) begin
			phase_q <= phase_n;
			pos_q   <= pos_n;
			check_q <= check_n;
			prev_q  <= prev_n;
			len_q   <= len_n;
			low_q   <= low_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || frame.ready) begin
			out_valid_q <= take && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit) begin
			out_byte_q <= r_byte;
			out_pv_q   <= r_pv;
			out_done_q <= r_done;
			out_st_q   <= r_st;
		end
	end

	assign frame.valid         = out_valid_q;
	assign frame.payload_byte  = out_byte_q;
	assign frame.payload_valid = out_pv_q;
	assign frame.frame_done    = out_done_q;
	assign frame.status        = out_st_q;

endmodule

`default_nettype wire

>>> hw/rtl/serial_frame_receiver_crc16_core.sv
// ----------------------------------------------------------------------------
// serial_frame_receiver_crc16_core
// Receives STX/address/length/command frames byte by byte, gives out the
// data bytes and ends each accepted frame with a status.
// ----------------------------------------------------------------------------
//  channel  direction  handshake       payload
//  rx       in         valid/ready     rx_byte[7:0]
//  frame    out        valid/ready     payload_byte, payload_valid,
//                                      frame_done, status[1:0]
//  apb      in         psel/penable    paddr[2:0], pwdata, prdata
//
//  one byte per cycle sustained while the result channel is not stalled;
//  a byte sits in the input register, then parser logic updates state and
//  loads the result register on the next edge, for bytes that give a result
//  arst_n clears state to hunting and config to its defaults
//  a stalled result register holds the byte in the input register and
//  deasserts rx.ready; no byte is dropped
// ----------------------------------------------------------------------------
`default_nettype none

module serial_frame_receiver_crc16_core
	import sfr_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	sfr_byte_if.sink                rx,
	sfr_result_if.source            frame,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready
);

	cfg_t       cfg;
	logic       take;
	logic       valid_s1;
	logic [7:0] byte_s1;

	sfr_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sfr_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (rx),
		.take     (take),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	sfr_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1),
		.take     (take),
		.frame    (frame)
	);

endmodule

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Feeds framed and malformed byte streams into the frame receiver, predicts
// every data byte and end-of-frame status in step with the accepted bytes,
// and compares them in order against the result channel under random
// stalls and gaps, across several command and length register settings.
// ----------------------------------------------------------------------------

module testbench;
	import sfr_pkg::*;

	localparam int unsigned QUIET_LIMIT = 3000;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned MAX_REPORTS = 50;

	typedef enum logic [2:0] {
		HUNT_START, WAIT_ADDR, LEN_LOW, LEN_HIGH, WAIT_CMD, CMD_MATCHED, CMD_REJECTED,
		IN_BODY
	} parse_phase_t;

	typedef struct packed {
		logic [7:0] data;
		logic       data_ok;
		logic       done;
		status_t    st;
	} frame_result_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	sfr_byte_if rx_bus ();
	sfr_result_if frame_bus ();

	serial_frame_receiver_crc16_core DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx      (rx_bus),
		.frame   (frame_bus),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// receiver model state
	parse_phase_t ph;
	logic [15:0] remaining;
	logic [15:0] sum;
	logic [7:0] prev;
	logic [15:0] len_seen;
	logic [7:0] sum_lo;
	logic [7:0] want_cmd;
	logic [15:0] want_len;

	logic [7:0] rx_pending[$];
	frame_result_t due_results[$];
	frame_result_t head;

	int rx_idle_pct = 0;
	int res_stall_pct = 0;
	int rx_wait = 0;
	int res_wait = 0;
	int fault_count = 0;
	int unsigned quiet = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [15:0] sum_step(input logic [15:0] s, input logic [7:0] p,
			input logic [7:0] b);
		logic [15:0] r;
		r = {s[14:0], 1'b0};
		if (s[15])
			r = r ^ CHECK_POLY;
		return r ^ {p, b};
	endfunction

	function automatic void fold(input logic [7:0] b);
		sum = sum_step(sum, prev, b);
		prev = b;
	endfunction

	function automatic void take_body(input logic [7:0] b, input logic [16:0] left);
		if (left == 17'd0) begin
			ph = HUNT_START;
			return;
		end
		remaining = 16'(left - 17'd1);
		ph = IN_BODY;
		if (left > 17'd2) begin
			fold(b);
			due_results.push_back(frame_result_t'{data: b, data_ok: 1'b1, done: 1'b0,
				st: ST_OK});
		end else if (left == 17'd2) begin
			sum_lo = b;
		end else begin
			ph = HUNT_START;
			due_results.push_back(frame_result_t'{data: 8'h00, data_ok: 1'b0, done: 1'b1,
				st: ({b, sum_lo} == sum) ? ST_OK : ST_CHECK_ERROR});
		end
	endfunction

	function automatic void parse_byte(input logic [7:0] b);
		case (ph)
			HUNT_START: begin
				if (b == START_BYTE) begin
					sum = {8'h00, b};
					prev = b;
					ph = WAIT_ADDR;
				end
			end
			WAIT_ADDR: begin
				if (b == ADDRESS_BYTE) begin
					fold(b);
					ph = LEN_LOW;
				end else begin
					ph = HUNT_START;
				end
			end
			LEN_LOW: begin
				fold(b);
				len_seen = {8'h00, b};
				ph = LEN_HIGH;
			end
			LEN_HIGH: begin
				fold(b);
				len_seen[15:8] = b;
				ph = WAIT_CMD;
			end
			WAIT_CMD: begin
				fold(b);
				ph = (b == want_cmd) ? CMD_MATCHED : CMD_REJECTED;
			end
			CMD_REJECTED: ph = HUNT_START;
			CMD_MATCHED: begin
				if (len_seen != want_len || len_seen == 16'h0000) begin
					ph = HUNT_START;
					due_results.push_back(frame_result_t'{data: 8'h00, data_ok: 1'b0,
						done: 1'b1, st: ST_LEN_MISMATCH});
				end else begin
					take_body(b, {1'b0, len_seen} + 17'd1);
				end
			end
			default: take_body(b, {1'b0, remaining});
		endcase
	endfunction

	function automatic int pick_pause(input int pct);
		if ($urandom_range(99) >= pct)
			return 0;
		if ($urandom_range(9) < 8)
			return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	function automatic logic [7:0] pick_data();
		case ($urandom_range(9))
			0: return START_BYTE;
			1: return ADDRESS_BYTE;
			default: return 8'($urandom);
		endcase
	endfunction

	// queues one frame, cut short to cut bytes when cut is positive and below the frame size; returns the bytes queued
	function automatic int queue_frame(input logic [7:0] cmd, input logic [15:0] len,
			input int n_data, input bit corrupt, input int cut);
		logic [7:0] bytes[$];
		logic [15:0] s;
		logic [7:0] p;
		int stop;
		bytes = {START_BYTE, ADDRESS_BYTE, len[7:0], len[15:8], cmd};
		repeat (n_data) bytes.push_back(pick_data());
		s = {8'h00, START_BYTE};
		p = START_BYTE;
		for (int i = 1; i < bytes.size(); i++) begin
			s = sum_step(s, p, bytes[i]);
			p = bytes[i];
		end
		if (corrupt)
			s = s ^ 16'($urandom_range(1, 65535));
		bytes.push_back(s[7:0]);
		bytes.push_back(s[15:8]);
		stop = (cut > 0 && cut < bytes.size()) ? cut : bytes.size();
		for (int i = 0; i < stop; i++)
			rx_pending.push_back(bytes[i]);
		return stop;
	endfunction

	task automatic reg_write(input logic idx, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_EXP_CMD)
			want_cmd = value[7:0];
		else
			want_len = value[15:0];
	endtask

	task automatic drain();
		while (rx_pending.size() != 0 || due_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(input logic [7:0] cmd, input logic [15:0] len, input int target,
			input int rx_pct, input int res_pct);
		int n;
		int kind;
		int body;
		logic [7:0] wrong;
		logic [7:0] b;
		logic [15:0] other;
		rx_idle_pct = rx_pct;
		res_stall_pct = res_pct;
		reg_write(REG_EXP_CMD, {24'h0, cmd});
		reg_write(REG_EXP_LEN, {16'h0, len});
		n = 0;
		body = (len <= 16'd64) ? int'(len) - 1 : 4;
		while (n < target) begin
			kind = $urandom_range(99);
			wrong = cmd ^ 8'($urandom_range(1, 255));
			other = 16'($urandom);
			if (other == len)
				other = len + 16'd1;
			if ($urandom_range(7) == 0)
				other = 16'h0000;
			if (len > 16'd64 && (kind < 65 || kind >= 94))
				kind = 75;
			if (kind < 55) begin
				n += queue_frame(cmd, len, body, 1'b0, 0);
			end else if (kind < 65) begin
				n += queue_frame(cmd, len, body, 1'b1, 0);
			end else if (kind < 73) begin
				n += queue_frame(wrong, len, body, 1'b0, 0);
			end else if (kind < 82) begin
				n += queue_frame(cmd, other, body, 1'b0, 6 + $urandom_range(3));
			end else if (kind < 88) begin
				b = 8'($urandom);
				if (b == ADDRESS_BYTE)
					b = 8'h7F;
				rx_pending.push_back(START_BYTE);
				rx_pending.push_back(b);
			end else if (kind < 94) begin
				repeat ($urandom_range(1, 4)) rx_pending.push_back(8'($urandom));
			end else begin
				n += queue_frame(cmd, len, body, 1'b0, $urandom_range(1, body + 6));
			end
		end
	endtask

	// byte driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_bus.valid <= 1'b0;
			rx_bus.rx_byte <= 8'h00;
		end else begin
			if (rx_bus.valid && rx_bus.ready) begin
				parse_byte(rx_bus.rx_byte);
				void'(rx_pending.pop_front());
				rx_wait = pick_pause(rx_idle_pct);
			end
			if (rx_bus.valid && !rx_bus.ready) begin
				// hold the item until taken
			end else if (rx_wait > 0) begin
				rx_wait--;
				rx_bus.valid <= 1'b0;
			end else if (rx_pending.size() > 0) begin
				rx_bus.valid <= 1'b1;
				rx_bus.rx_byte <= rx_pending[0];
			end else begin
				rx_bus.valid <= 1'b0;
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_bus.ready <= 1'b0;
		end else begin
			if (frame_bus.valid && frame_bus.ready) begin
				if (due_results.size() == 0) begin
					fault_count++;
					if (fault_count <= MAX_REPORTS)
						$display("%0t: unexpected item: byte=%02h pv=%b done=%b status=%0d",
							$time, frame_bus.payload_byte, frame_bus.payload_valid,
							frame_bus.frame_done, frame_bus.status);
				end else begin
					head = due_results.pop_front();
					if (frame_bus.payload_byte !== head.data
							|| frame_bus.payload_valid !== head.data_ok
							|| frame_bus.frame_done !== head.done
							|| frame_bus.status !== head.st) begin
						fault_count++;
						if (fault_count <= MAX_REPORTS)
							$display({"%0t: mismatch: expected byte=%02h pv=%b done=%b ",
								"status=%0d, actual byte=%02h pv=%b done=%b status=%0d"},
								$time, head.data, head.data_ok, head.done, head.st,
								frame_bus.payload_byte, frame_bus.payload_valid,
								frame_bus.frame_done, frame_bus.status);
					end
				end
			end
			if (res_wait > 0) begin
				res_wait--;
				frame_bus.ready <= 1'b0;
			end else begin
				frame_bus.ready <= 1'b1;
				res_wait = pick_pause(res_stall_pct);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((rx_bus.valid && rx_bus.ready) || (frame_bus.valid && frame_bus.ready))
				quiet <= 0;
			else
				quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		rx_bus.valid = 1'b0;
		rx_bus.rx_byte = 8'h00;
		frame_bus.ready = 1'b0;
		ph = HUNT_START;
		remaining = 16'h0000;
		sum = 16'h0000;
		prev = 8'h00;
		len_seen = 16'h0000;
		sum_lo = 8'h00;
		want_cmd = 8'd176;
		want_len = 16'd1007;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// defaults after reset: matching command with short length, then wrong command
		void'(queue_frame(8'd176, 16'd5, 0, 1'b0, 6));
		void'(queue_frame(8'd177, 16'd1007, 0, 1'b0, 6));
		drain();

		reg_write(REG_EXP_CMD, 32'h0000_0000);
		reg_write(REG_EXP_LEN, 32'h0000_0001);
		rx_pending.push_back(8'hFF);
		rx_pending.push_back(8'h00);
		rx_pending.push_back(ADDRESS_BYTE);
		// start byte as the address byte is not a new start
		rx_pending.push_back(START_BYTE);
		rx_pending.push_back(START_BYTE);
		rx_pending.push_back(START_BYTE);
		rx_pending.push_back(8'h7F);
		void'(queue_frame(8'h00, 16'd1, 0, 1'b0, 0));
		void'(queue_frame(8'h00, 16'd1, 0, 1'b1, 0));
		void'(queue_frame(8'hFF, 16'd1, 0, 1'b0, 6));
		void'(queue_frame(8'h00, 16'd0, 0, 1'b0, 6));
		drain();

		reg_write(REG_EXP_CMD, 32'h0000_00FF);
		reg_write(REG_EXP_LEN, 32'h0000_0003);
		void'(queue_frame(8'hFF, 16'd3, 2, 1'b0, 0));
		void'(queue_frame(8'hFF, 16'hFFFF, 0, 1'b0, 6));
		void'(queue_frame(8'hFF, 16'd3, 2, 1'b1, 0));
		drain();

		run_phase(8'h00, 16'd1, 250, 0, 0);
		drain();
		run_phase(8'hFF, 16'd4, 250, 40, 0);
		drain();
		run_phase(8'($urandom), 16'($urandom_range(1, 16)), 300, 0, 40);
		drain();
		run_phase(START_BYTE, 16'd2, 250, 20, 20);
		drain();
		run_phase(ADDRESS_BYTE, 16'($urandom_range(1, 40)), 300, 40, 40);
		drain();
		run_phase(8'($urandom), 16'd64, 300, 10, 0);
		drain();
		// largest length word, frames rejected on the sixth byte
		run_phase(8'($urandom), 16'hFFFF, 100, 5, 5);
		drain();

		if (fault_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
